@@ sv/ppdc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppdc_pkg - shared types and constants for the position PID controller
// Field widths, register indexes, reset values, pipeline control struct.
// ----------------------------------------------------------------------------
package ppdc_pkg;

	localparam int IN_W      = 32;
	localparam int ERR_W     = 33;
	localparam int DIFF_W    = 34;
	localparam int GAIN_W    = 24;
	localparam int ILIM_W    = 20;
	localparam int OLIM_W    = 16;
	localparam int BAND_W    = 24;
	localparam int DRIVE_W   = 33;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = GAIN_W + 1 + ERR_W;
	localparam int DPROD_W   = GAIN_W + 1 + DIFF_W;

	localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND = 3'd5;

	localparam logic [ILIM_W-1:0] ILIM_RST = 20'd80000;
	localparam logic [OLIM_W-1:0] OLIM_RST = 16'd10000;
	localparam logic [BAND_W-1:0] BAND_RST = 24'd19661;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [ILIM_W-1:0] ilim;
		logic [OLIM_W-1:0] olim;
		logic [BAND_W-1:0] band;
	} cfg_t;

	// load strobes, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_ld_t;

endpackage

@@ sv/position_pid_deadband_clamped.sv @@
// ----------------------------------------------------------------------------
// position_pid_deadband_clamped - positional PID with dead band and clamps
// A sample transfer passes the stage registers s1 through s6 in order; its
// drive is valid once it sits in s6 and leaves when drive_stall is low.
// Throughput: one sample per cycle; six elastic stages fill while later ones
// are held, so a stalled drive blocks input only once all six are full.
// Reset clears stage valids, integral term and last error, and loads the
// register defaults (gains 0, limits 80000 and 10000, dead band 0.3).
// ----------------------------------------------------------------------------
module position_pid_deadband_clamped import ppdc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic signed [IN_W-1:0]    target,
	input  logic signed [IN_W-1:0]    feedback,
	output logic                      drive_valid,
	input  logic                      drive_stall,
	output logic signed [DRIVE_W-1:0] drive
);

	cfg_t                      cfg_q;
	logic [6:1]                v_q;
	logic [7:1]                rdy;
	logic [6:1]                v_prev;
	pipe_ld_t                  ld;
	logic signed [ERR_W-1:0]   errb_s3;
	logic signed [DIFF_W-1:0]  diff_s3;
	logic                      inside_s3;
	logic signed [PROD_W-1:0]  p_s4;
	logic signed [PROD_W-1:0]  i_s4;
	logic signed [DPROD_W-1:0] d_s4;
	logic                      inside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= '0;
			cfg_q.ki   <= '0;
			cfg_q.kd   <= '0;
			cfg_q.ilim <= ILIM_RST;
			cfg_q.olim <= OLIM_RST;
			cfg_q.band <= BAND_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KP:   cfg_q.kp   <= cfg_data[GAIN_W-1:0];
				REG_KI:   cfg_q.ki   <= cfg_data[GAIN_W-1:0];
				REG_KD:   cfg_q.kd   <= cfg_data[GAIN_W-1:0];
				REG_ILIM: cfg_q.ilim <= cfg_data[ILIM_W-1:0];
				REG_OLIM: cfg_q.olim <= cfg_data[OLIM_W-1:0];
				REG_BAND: cfg_q.band <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage takes a new transfer when empty or when its occupant moves on
	always_comb begin
		rdy[7] = !drive_stall;
		for (int k = 6; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign v_prev = {v_q[5:1], sample_valid};

	assign ld.s1 = rdy[1] && v_prev[1];
	assign ld.s2 = rdy[2] && v_prev[2];
	assign ld.s3 = rdy[3] && v_prev[3];
	assign ld.s4 = rdy[4] && v_prev[4];
	assign ld.s5 = rdy[5] && v_prev[5];
	assign ld.s6 = rdy[6] && v_prev[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= 6; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_prev[k];
				end
			end
		end
	end

	assign sample_stall = !rdy[1];
	assign drive_valid  = v_q[6];

	ppdc_err u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.target    (target),
		.feedback  (feedback),
		.band      (cfg_q.band),
		.errb_s3   (errb_s3),
		.diff_s3   (diff_s3),
		.inside_s3 (inside_s3)
	);

	ppdc_mul u_mul (
		.clk       (clk),
		.ld        (ld),
		.cfg       (cfg_q),
		.errb_s3   (errb_s3),
		.diff_s3   (diff_s3),
		.inside_s3 (inside_s3),
		.p_s4      (p_s4),
		.i_s4      (i_s4),
		.d_s4      (d_s4),
		.inside_s4 (inside_s4)
	);

	ppdc_acc #(
		.FRAC_BITS (FRAC_BITS)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.ilim      (cfg_q.ilim),
		.olim      (cfg_q.olim),
		.p_s4      (p_s4),
		.i_s4      (i_s4),
		.d_s4      (d_s4),
		.inside_s4 (inside_s4),
		.drive     (drive)
	);

`ifndef SYNTH
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (&v_q))
		else $error("input stalled with a free stage");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> v_q[1])
		else $error("accepted transfer lost at first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && !drive_stall && !v_q[5]) |=> !drive_valid)
		else $error("drive repeated after transfer");
`endif

endmodule

@@ sv/ppdc_err.sv @@
// ----------------------------------------------------------------------------
// ppdc_err - error, dead band and error difference
// Registers the sample, forms the error, applies the dead band and keeps
// the last error for the derivative path.
// ----------------------------------------------------------------------------
module ppdc_err import ppdc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pipe_ld_t                 ld,
	input  logic signed [IN_W-1:0]   target,
	input  logic signed [IN_W-1:0]   feedback,
	input  logic [BAND_W-1:0]        band,
	output logic signed [ERR_W-1:0]  errb_s3,
	output logic signed [DIFF_W-1:0] diff_s3,
	output logic                     inside_s3
);

	logic signed [IN_W-1:0]   target_s1;
	logic signed [IN_W-1:0]   feedback_s1;
	logic signed [ERR_W-1:0]  err_raw;
	logic signed [DIFF_W-1:0] err_x;
	logic signed [DIFF_W-1:0] band_x;
	logic                     in_band;
	logic signed [ERR_W-1:0]  err_s2;
	logic                     inside_s2;
	logic signed [ERR_W-1:0]  errb;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ERR_W-1:0]  last_err_q;

	assign err_raw = $signed({target_s1[IN_W-1], target_s1})
		- $signed({feedback_s1[IN_W-1], feedback_s1});
	assign err_x   = $signed({err_raw[ERR_W-1], err_raw});
	assign band_x  = $signed({{(DIFF_W-BAND_W){1'b0}}, band});
	// strictly inside the band
	assign in_band = (err_x < band_x) && (err_x > -band_x);

	assign errb = inside_s2 ? '0 : err_s2;
	assign diff = $signed({errb[ERR_W-1], errb})
		- $signed({last_err_q[ERR_W-1], last_err_q});

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			target_s1   <= target;
			feedback_s1 <= feedback;
		end
		if (ld.s2) begin
			err_s2    <= err_raw;
			inside_s2 <= in_band;
		end
		if (ld.s3) begin
			errb_s3   <= errb;
			diff_s3   <= diff;
			inside_s3 <= inside_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
		end else if (ld.s3) begin
			last_err_q <= errb;
		end
	end

endmodule

@@ sv/ppdc_mul.sv @@
// ----------------------------------------------------------------------------
// ppdc_mul - gain products
// Three parallel signed multiplies: kp*err, ki*err and kd*(err - last).
// ----------------------------------------------------------------------------
module ppdc_mul import ppdc_pkg::*; (
	input  logic                      clk,
	input  pipe_ld_t                  ld,
	input  cfg_t                      cfg,
	input  logic signed [ERR_W-1:0]   errb_s3,
	input  logic signed [DIFF_W-1:0]  diff_s3,
	input  logic                      inside_s3,
	output logic signed [PROD_W-1:0]  p_s4,
	output logic signed [PROD_W-1:0]  i_s4,
	output logic signed [DPROD_W-1:0] d_s4,
	output logic                      inside_s4
);

	logic signed [PROD_W-1:0]  p_prod;
	logic signed [PROD_W-1:0]  i_prod;
	logic signed [DPROD_W-1:0] d_prod;

	assign p_prod = $signed({1'b0, cfg.kp}) * errb_s3;
	assign i_prod = $signed({1'b0, cfg.ki}) * errb_s3;
	assign d_prod = $signed({1'b0, cfg.kd}) * diff_s3;

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			p_s4      <= p_prod;
			i_s4      <= i_prod;
			d_s4      <= d_prod;
			inside_s4 <= inside_s3;
		end
	end

endmodule

@@ sv/ppdc_acc.sv @@
// ----------------------------------------------------------------------------
// ppdc_acc - integral accumulator and output saturation
// Floors the products, updates and clamps the integral term, sums the
// drive, saturates it (zero inside the dead band) and holds it in the output register.
// ----------------------------------------------------------------------------
module ppdc_acc import ppdc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pipe_ld_t                  ld,
	input  logic [ILIM_W-1:0]         ilim,
	input  logic [OLIM_W-1:0]         olim,
	input  logic signed [PROD_W-1:0]  p_s4,
	input  logic signed [PROD_W-1:0]  i_s4,
	input  logic signed [DPROD_W-1:0] d_s4,
	input  logic                      inside_s4,
	output logic signed [DRIVE_W-1:0] drive
);

	localparam int IW     = ILIM_W + FRAC_BITS + 1;
	localparam int ISUM_W = ((IW > PROD_W) ? IW : PROD_W) + 1;
	localparam int PD_W   = ((PROD_W > DPROD_W) ? PROD_W : DPROD_W) + 1;
	localparam int TOT_W  = ((PD_W > IW) ? PD_W : IW) + 1;

	logic signed [PROD_W-1:0]  p_sh;
	logic signed [PROD_W-1:0]  i_sh;
	logic signed [DPROD_W-1:0] d_sh;
	logic signed [ISUM_W-1:0]  isum;
	logic signed [ISUM_W-1:0]  ilim_v;
	logic signed [ISUM_W-1:0]  iclamp;
	logic signed [IW-1:0]      integ_q;
	logic signed [PD_W-1:0]    pd;
	logic signed [PD_W-1:0]    pd_s5;
	logic                      inside_s5;
	logic signed [TOT_W-1:0]   tot;
	logic signed [TOT_W-1:0]   olim_v;
	logic signed [TOT_W-1:0]   oclamp;

	// arithmetic shifts floor toward minus infinity
	assign p_sh = p_s4 >>> FRAC_BITS;
	assign i_sh = i_s4 >>> FRAC_BITS;
	assign d_sh = d_s4 >>> FRAC_BITS;

	assign isum = $signed({{(ISUM_W-IW){integ_q[IW-1]}}, integ_q})
		+ $signed({{(ISUM_W-PROD_W){i_sh[PROD_W-1]}}, i_sh});
	assign ilim_v = $signed({{(ISUM_W-ILIM_W-FRAC_BITS){1'b0}}, ilim,
		{FRAC_BITS{1'b0}}});

	always_comb begin
		if (isum > ilim_v) begin
			iclamp = ilim_v;
		end else if (isum < -ilim_v) begin
			iclamp = -ilim_v;
		end else begin
			iclamp = isum;
		end
	end

	assign pd = $signed({{(PD_W-PROD_W){p_sh[PROD_W-1]}}, p_sh})
		+ $signed({{(PD_W-DPROD_W){d_sh[DPROD_W-1]}}, d_sh});

	assign tot = $signed({{(TOT_W-PD_W){pd_s5[PD_W-1]}}, pd_s5})
		+ $signed({{(TOT_W-IW){integ_q[IW-1]}}, integ_q});
	assign olim_v = $signed({{(TOT_W-OLIM_W-FRAC_BITS){1'b0}}, olim,
		{FRAC_BITS{1'b0}}});

	always_comb begin
		if (tot > olim_v) begin
			oclamp = olim_v;
		end else if (tot < -olim_v) begin
			oclamp = -olim_v;
		end else begin
			oclamp = tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ld.s5) begin
			integ_q <= iclamp[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			pd_s5     <= pd;
			inside_s5 <= inside_s4;
		end
		if (ld.s6) begin
			drive <= inside_s5 ? '0 : oclamp[DRIVE_W-1:0];
		end
	end

endmodule
